### src/tep_pkg.sv
// ----------------------------------------------------------------------------
// Text escape attribute parser package
// Shared word types, parser mode codes, character codes and colour constants.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package tep_pkg;

    // Input word: one message byte and its start-of-message mark.
    typedef struct packed {
        logic [7:0] char_in;
        logic       start_of_message;
    } char_word_t;

    // Output word: one glyph and the attributes in force when it was taken.
    typedef struct packed {
        logic [7:0] glyph_code;
        logic       is_bold;
        logic       is_italic;
        logic       is_underline;
        logic       is_strike;
        logic [7:0] text_red;
        logic [7:0] text_green;
        logic [7:0] text_blue;
        logic [7:0] back_red;
        logic [7:0] back_green;
        logic [7:0] back_blue;
        logic       back_clear;
    } glyph_word_t;

    // Parser modes.
    typedef enum logic [2:0] {
        MODE_IDLE = 3'd0,
        MODE_ESC  = 3'd1,
        MODE_FLAG = 3'd2,
        MODE_CSEL = 3'd3,
        MODE_SKIP = 3'd4,
        MODE_HEX  = 3'd5
    } mode_t;

    // Style flag bit positions.
    localparam logic [1:0] FLAG_BOLD      = 2'd0;
    localparam logic [1:0] FLAG_ITALIC    = 2'd1;
    localparam logic [1:0] FLAG_UNDERLINE = 2'd2;
    localparam logic [1:0] FLAG_STRIKE    = 2'd3;

    // Character codes used by the escape syntax.
    localparam logic [7:0] CH_BSLASH = 8'h5C;
    localparam logic [7:0] CH_B      = 8'h62;
    localparam logic [7:0] CH_I      = 8'h69;
    localparam logic [7:0] CH_U      = 8'h75;
    localparam logic [7:0] CH_S      = 8'h73;
    localparam logic [7:0] CH_C      = 8'h63;
    localparam logic [7:0] CH_H      = 8'h68;
    localparam logic [7:0] CH_ZERO   = 8'h30;
    localparam logic [7:0] CH_ONE    = 8'h31;
    localparam logic [7:0] CH_HASH   = 8'h23;

    // Colour defaults; bit 24 of the highlight marks it transparent.
    localparam logic [23:0] WHITE_RGB  = 24'hFFFFFF;
    localparam logic [24:0] BACK_CLEAR = 25'h1000000;

    // Hex digit counting: digits past HEX_KEEP are ignored, HEX_MAX ends it.
    localparam logic [2:0] HEX_KEEP = 3'd6;
    localparam logic [2:0] HEX_MAX  = 3'd7;
    localparam logic [2:0] HEX_TOP  = 3'd5;

    // Hex digit decode: returns {valid, nibble}.
    function automatic logic [4:0] nibble_of(input logic [7:0] ch);
        logic [4:0] res;
        res = 5'd0;
        if (ch >= 8'h30 && ch <= 8'h39)
        begin
            res = {1'b1, 4'(ch - 8'h30)};
        end
        else if (ch >= 8'h61 && ch <= 8'h66)
        begin
            res = {1'b1, 4'(ch - 8'h57)};
        end
        else if (ch >= 8'h41 && ch <= 8'h46)
        begin
            res = {1'b1, 4'(ch - 8'h37)};
        end
        return res;
    endfunction

endpackage

### src/tep_parse.sv
// ----------------------------------------------------------------------------
// Text escape parser state
// Parser mode and attributes; works out one byte per cycle while advance is high.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tep_parse
(
    input  logic                clk,
    input  logic                rst_n,
    input  tep_pkg::char_word_t item,
    input  logic                advance,
    output logic                emit,
    output tep_pkg::glyph_word_t result
);

    tep_pkg::mode_t mode_reg, mode_next;
    logic [1:0]     flag_target_reg, flag_target_next;
    logic           colour_target_reg, colour_target_next;
    logic [2:0]     hex_count_reg, hex_count_next;
    logic [3:0]     style_reg, style_next;
    logic [23:0]    text_reg, text_next;
    logic [24:0]    back_reg, back_next;

    // State as seen by this byte: a start-of-message mark restores reset values.
    tep_pkg::mode_t cur_mode;
    logic [1:0]     cur_flag_target;
    logic           cur_colour_target;
    logic [2:0]     cur_hex_count;
    logic [3:0]     cur_style;
    logic [23:0]    cur_text;
    logic [24:0]    cur_back;
    logic [4:0]     nib;
    logic [23:0]    hex_bits;
    logic [2:0]     hex_pos;

    always_comb
    begin
        cur_mode          = item.start_of_message ? tep_pkg::MODE_IDLE : mode_reg;
        cur_flag_target   = item.start_of_message ? 2'd0 : flag_target_reg;
        cur_colour_target = item.start_of_message ? 1'b0 : colour_target_reg;
        cur_hex_count     = item.start_of_message ? 3'd0 : hex_count_reg;
        cur_style         = item.start_of_message ? 4'd0 : style_reg;
        cur_text          = item.start_of_message ? tep_pkg::WHITE_RGB : text_reg;
        cur_back          = item.start_of_message ? tep_pkg::BACK_CLEAR : back_reg;
    end

    // Nibble placement for the current hex digit, high nibble first.
    always_comb
    begin
        nib      = tep_pkg::nibble_of(item.char_in);
        hex_pos  = tep_pkg::HEX_TOP - cur_hex_count;
        hex_bits = {20'd0, nib[3:0]} << {hex_pos, 2'b00};
    end

    // Next state and emit decision.
    always_comb
    begin
        mode_next          = tep_pkg::MODE_IDLE;
        flag_target_next   = cur_flag_target;
        colour_target_next = cur_colour_target;
        hex_count_next     = cur_hex_count;
        style_next         = cur_style;
        text_next          = cur_text;
        back_next          = cur_back;
        emit               = 1'b0;
        case (cur_mode)
            tep_pkg::MODE_ESC:
            begin
                case (item.char_in)
                    tep_pkg::CH_B:
                    begin
                        flag_target_next = tep_pkg::FLAG_BOLD;
                        mode_next        = tep_pkg::MODE_FLAG;
                    end
                    tep_pkg::CH_I:
                    begin
                        flag_target_next = tep_pkg::FLAG_ITALIC;
                        mode_next        = tep_pkg::MODE_FLAG;
                    end
                    tep_pkg::CH_U:
                    begin
                        flag_target_next = tep_pkg::FLAG_UNDERLINE;
                        mode_next        = tep_pkg::MODE_FLAG;
                    end
                    tep_pkg::CH_S:
                    begin
                        flag_target_next = tep_pkg::FLAG_STRIKE;
                        mode_next        = tep_pkg::MODE_FLAG;
                    end
                    tep_pkg::CH_C:
                    begin
                        colour_target_next = 1'b0;
                        mode_next          = tep_pkg::MODE_CSEL;
                    end
                    tep_pkg::CH_H:
                    begin
                        colour_target_next = 1'b1;
                        mode_next          = tep_pkg::MODE_CSEL;
                    end
                    default:
                    begin
                        mode_next = tep_pkg::MODE_IDLE;
                    end
                endcase
            end
            tep_pkg::MODE_FLAG:
            begin
                if (item.char_in == tep_pkg::CH_ZERO)
                begin
                    style_next[cur_flag_target] = 1'b1;
                end
                else if (item.char_in == tep_pkg::CH_ONE)
                begin
                    style_next[cur_flag_target] = 1'b0;
                end
            end
            tep_pkg::MODE_CSEL:
            begin
                if (item.char_in == tep_pkg::CH_ZERO)
                begin
                    if (cur_colour_target)
                    begin
                        back_next = tep_pkg::BACK_CLEAR;
                    end
                    else
                    begin
                        text_next = tep_pkg::WHITE_RGB;
                    end
                    mode_next = tep_pkg::MODE_SKIP;
                end
                else if (item.char_in == tep_pkg::CH_HASH)
                begin
                    if (cur_colour_target)
                    begin
                        back_next = 25'd0;
                    end
                    else
                    begin
                        text_next = 24'd0;
                    end
                    hex_count_next = 3'd0;
                    mode_next      = tep_pkg::MODE_HEX;
                end
            end
            tep_pkg::MODE_SKIP:
            begin
                mode_next = tep_pkg::MODE_IDLE;
            end
            tep_pkg::MODE_HEX:
            begin
                // A non-hex byte or the byte after the seventh digit ends the run.
                if (cur_hex_count != tep_pkg::HEX_MAX && nib[4])
                begin
                    if (cur_hex_count < tep_pkg::HEX_KEEP)
                    begin
                        if (cur_colour_target)
                        begin
                            back_next = cur_back | {1'b0, hex_bits};
                        end
                        else
                        begin
                            text_next = cur_text | hex_bits;
                        end
                    end
                    hex_count_next = cur_hex_count + 3'd1;
                    mode_next      = tep_pkg::MODE_HEX;
                end
            end
            default:
            begin
                if (item.char_in == tep_pkg::CH_BSLASH)
                begin
                    mode_next = tep_pkg::MODE_ESC;
                end
                else
                begin
                    emit = 1'b1;
                end
            end
        endcase
    end

    // Result word carries the attributes in force before this byte.
    always_comb
    begin
        result.glyph_code   = item.char_in;
        result.is_bold      = cur_style[tep_pkg::FLAG_BOLD];
        result.is_italic    = cur_style[tep_pkg::FLAG_ITALIC];
        result.is_underline = cur_style[tep_pkg::FLAG_UNDERLINE];
        result.is_strike    = cur_style[tep_pkg::FLAG_STRIKE];
        result.text_red     = cur_text[23:16];
        result.text_green   = cur_text[15:8];
        result.text_blue    = cur_text[7:0];
        result.back_red     = cur_back[23:16];
        result.back_green   = cur_back[15:8];
        result.back_blue    = cur_back[7:0];
        result.back_clear   = cur_back[24];
    end

    // Parser state registers, updated when a word leaves the input register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg          <= tep_pkg::MODE_IDLE;
            flag_target_reg   <= 2'd0;
            colour_target_reg <= 1'b0;
            hex_count_reg     <= 3'd0;
            style_reg         <= 4'd0;
            text_reg          <= tep_pkg::WHITE_RGB;
            back_reg          <= tep_pkg::BACK_CLEAR;
        end
        else if (advance)
        begin
            mode_reg          <= mode_next;
            flag_target_reg   <= flag_target_next;
            colour_target_reg <= colour_target_next;
            hex_count_reg     <= hex_count_next;
            style_reg         <= style_next;
            text_reg          <= text_next;
            back_reg          <= back_next;
        end
    end

`ifndef SYNTHESIS
    // A fresh message that does not open with a backslash always draws.
    assert property (@(posedge clk) disable iff (!rst_n)
        (item.start_of_message && item.char_in != tep_pkg::CH_BSLASH) |-> emit)
        else $error("start of message byte not emitted");

    // Only the idle mode draws, and it stays idle afterwards.
    assert property (@(posedge clk) disable iff (!rst_n)
        (advance && emit) |=> (mode_reg == tep_pkg::MODE_IDLE))
        else $error("parser left idle after emitting");

    // A hex run counts up one digit at a time from zero.
    assert property (@(posedge clk) disable iff (!rst_n)
        (advance && mode_reg == tep_pkg::MODE_HEX && !item.start_of_message
         && mode_next == tep_pkg::MODE_HEX)
        |=> (hex_count_reg == $past(hex_count_reg) + 3'd1))
        else $error("hex digit count did not advance");
`endif

endmodule

### src/text_escape_attribute_parser_core.sv
// ----------------------------------------------------------------------------
// Text escape attribute parser core
// Strips in-band style and colour escapes from a byte stream and tags each
// drawn glyph with the attributes in force.
// ----------------------------------------------------------------------------
// Usage:
//   The char channel (char_valid, char_stall, char_word) takes one message
//   byte per word; start_of_message resets the attributes and the parser
//   before that byte. The glyph channel (glyph_valid, glyph_stall,
//   glyph_word) returns one word per drawn byte; escape bytes give none.
//   A word is taken at a clock edge where valid is high and stall is low.
//   Path: a taken byte is held in the input register, parsed there by
//   combinational logic and registered into the glyph register.
//   Throughput: one byte per cycle while char_stall is low, set by the
//   single parse step between the input register and the glyph register.
//   When glyph_stall holds a waiting glyph, bytes that draw nothing still
//   pass; a byte that draws waits in the input register and char_stall rises.
//   Reset clears both registers' valid bits and restores white text, a
//   transparent highlight and all style flags clear.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module text_escape_attribute_parser_core
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 char_valid,
    output logic                 char_stall,
    input  tep_pkg::char_word_t  char_word,
    output logic                 glyph_valid,
    input  logic                 glyph_stall,
    output tep_pkg::glyph_word_t glyph_word
);

    logic                 in_valid_reg;
    tep_pkg::char_word_t  in_word_reg;
    logic                 out_valid_reg;
    tep_pkg::glyph_word_t out_word_reg;
    logic                 emit;
    tep_pkg::glyph_word_t result;
    logic                 out_free;
    logic                 advance;

    // Handshake: the held byte moves on unless it draws and the output is full.
    assign out_free   = !out_valid_reg || !glyph_stall;
    assign advance    = in_valid_reg && (!emit || out_free);
    assign char_stall = in_valid_reg && !advance;

    tep_parse u_parse
    (
        .clk    (clk),
        .rst_n  (rst_n),
        .item   (in_word_reg),
        .advance(advance),
        .emit   (emit),
        .result (result)
    );

    // Input register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (!char_stall)
        begin
            in_valid_reg <= char_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (!char_stall && char_valid)
        begin
            in_word_reg <= char_word;
        end
    end

    // Glyph register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (out_free)
        begin
            out_valid_reg <= advance && emit;
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_free && advance && emit)
        begin
            out_word_reg <= result;
        end
    end

    assign glyph_valid = out_valid_reg;
    assign glyph_word  = out_word_reg;

`ifndef SYNTHESIS
    // Upstream is held off only while a byte waits in the input register.
    assert property (@(posedge clk) disable iff (!rst_n)
        char_stall |-> in_valid_reg)
        else $error("stall raised with empty input register");

    // A drawn byte that leaves the input register lands in the glyph register.
    assert property (@(posedge clk) disable iff (!rst_n)
        (advance && emit) |=> out_valid_reg)
        else $error("drawn byte lost");

    // A new glyph only appears after a byte was held in the input register.
    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(in_valid_reg))
        else $error("glyph appeared without an input byte");
`endif

endmodule

### bench/testbench.sv
// ----------------------------------------------------------------------------
// Text escape attribute parser testbench
// Streams message bytes into the parser, predicts every drawn glyph and its
// attributes with an in-bench copy of the parser state, and checks each
// glyph word in order. Directed escapes come first. Random runs of mostly
// well-formed escapes follow, under several sender and receiver idling phases.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module testbench;

    // Bench-only character codes.
    localparam logic [7:0] CH_SEMI    = 8'h3B;
    localparam logic [7:0] CH_LOWER_A = 8'h61;
    localparam logic [7:0] CH_UPPER_A = 8'h41;
    localparam logic [7:0] CH_LOWER_Q = 8'h71;
    localparam logic [7:0] CH_LOWER_X = 8'h78;
    localparam logic [7:0] CH_SEVEN   = 8'h37;
    localparam logic [7:0] CH_LETTER_M = 8'h4D;
    localparam logic [7:0] CH_LETTER_X = 8'h58;
    localparam logic [7:0] CH_LETTER_Y = 8'h59;
    localparam logic [7:0] CH_LETTER_Z = 8'h5A;

    localparam int RANDOM_PER_PHASE = 300;
    localparam int DRAIN_CYCLES     = 10;

    logic                 clk = 1'b0;
    logic                 rst_n = 1'b0;
    logic                 char_valid = 1'b0;
    logic                 char_stall;
    tep_pkg::char_word_t  char_word = '0;
    logic                 glyph_valid;
    logic                 glyph_stall = 1'b0;
    tep_pkg::glyph_word_t glyph_word;

    // Bytes waiting to be sent and glyphs waiting to come back.
    tep_pkg::char_word_t  pending_chars[$];
    tep_pkg::glyph_word_t expected_glyphs[$];

    int unsigned chars_queued = 0;
    int unsigned error_count = 0;
    int unsigned sender_idle_pct = 0;
    int unsigned receiver_stall_pct = 0;
    bit          char_taken = 1'b0;

    // Predicted parser state.
    tep_pkg::mode_t scan_mode;
    logic [1:0]     flag_sel;
    logic           colour_sel;
    logic [2:0]     hex_cnt;
    logic [3:0]     style_bits;
    logic [23:0]    text_rgb;
    logic [24:0]    back_rgb;

    text_escape_attribute_parser_core dut
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .char_valid  (char_valid),
        .char_stall  (char_stall),
        .char_word   (char_word),
        .glyph_valid (glyph_valid),
        .glyph_stall (glyph_stall),
        .glyph_word  (glyph_word)
    );

    // Clock and reset.
    initial
    begin
        forever #5 clk = ~clk;
    end

    initial
    begin
        repeat (10) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
    end

    // Returns the value of a hex digit, or -1 for any other byte.
    function automatic int digit_value(input logic [7:0] c);
        if (c >= tep_pkg::CH_ZERO && c <= tep_pkg::CH_ZERO + 8'd9)
        begin
            return int'(c - tep_pkg::CH_ZERO);
        end
        if (c >= CH_LOWER_A && c <= CH_LOWER_A + 8'd5)
        begin
            return int'(c - CH_LOWER_A) + 10;
        end
        if (c >= CH_UPPER_A && c <= CH_UPPER_A + 8'd5)
        begin
            return int'(c - CH_UPPER_A) + 10;
        end
        return -1;
    endfunction

    task automatic clear_attributes();
        scan_mode  = tep_pkg::MODE_IDLE;
        flag_sel   = tep_pkg::FLAG_BOLD;
        colour_sel = 1'b0;
        hex_cnt    = 3'd0;
        style_bits = 4'd0;
        text_rgb   = tep_pkg::WHITE_RGB;
        back_rgb   = tep_pkg::BACK_CLEAR;
    endtask

    // Advances the predicted parser by one byte and queues the glyph it draws.
    task automatic parse_char(input tep_pkg::char_word_t w);
        logic [7:0]           c;
        int                   nib;
        logic [23:0]          bits;
        tep_pkg::glyph_word_t g;
        bit                   draws;
        c = w.char_in;
        draws = 1'b0;
        if (w.start_of_message)
        begin
            clear_attributes();
        end
        case (scan_mode)
            tep_pkg::MODE_ESC:
            begin
                scan_mode = tep_pkg::MODE_IDLE;
                case (c)
                    tep_pkg::CH_B:
                    begin
                        flag_sel  = tep_pkg::FLAG_BOLD;
                        scan_mode = tep_pkg::MODE_FLAG;
                    end
                    tep_pkg::CH_I:
                    begin
                        flag_sel  = tep_pkg::FLAG_ITALIC;
                        scan_mode = tep_pkg::MODE_FLAG;
                    end
                    tep_pkg::CH_U:
                    begin
                        flag_sel  = tep_pkg::FLAG_UNDERLINE;
                        scan_mode = tep_pkg::MODE_FLAG;
                    end
                    tep_pkg::CH_S:
                    begin
                        flag_sel  = tep_pkg::FLAG_STRIKE;
                        scan_mode = tep_pkg::MODE_FLAG;
                    end
                    tep_pkg::CH_C:
                    begin
                        colour_sel = 1'b0;
                        scan_mode  = tep_pkg::MODE_CSEL;
                    end
                    tep_pkg::CH_H:
                    begin
                        colour_sel = 1'b1;
                        scan_mode  = tep_pkg::MODE_CSEL;
                    end
                    default: ;
                endcase
            end
            tep_pkg::MODE_FLAG:
            begin
                // A zero sets the flag and a one clears it.
                if (c == tep_pkg::CH_ZERO)
                begin
                    style_bits[flag_sel] = 1'b1;
                end
                else if (c == tep_pkg::CH_ONE)
                begin
                    style_bits[flag_sel] = 1'b0;
                end
                scan_mode = tep_pkg::MODE_IDLE;
            end
            tep_pkg::MODE_CSEL:
            begin
                scan_mode = tep_pkg::MODE_IDLE;
                if (c == tep_pkg::CH_ZERO)
                begin
                    if (colour_sel)
                    begin
                        back_rgb = tep_pkg::BACK_CLEAR;
                    end
                    else
                    begin
                        text_rgb = tep_pkg::WHITE_RGB;
                    end
                    scan_mode = tep_pkg::MODE_SKIP;
                end
                else if (c == tep_pkg::CH_HASH)
                begin
                    if (colour_sel)
                    begin
                        back_rgb = '0;
                    end
                    else
                    begin
                        text_rgb = '0;
                    end
                    hex_cnt = 3'd0;
                    scan_mode = tep_pkg::MODE_HEX;
                end
            end
            tep_pkg::MODE_SKIP:
            begin
                scan_mode = tep_pkg::MODE_IDLE;
            end
            tep_pkg::MODE_HEX:
            begin
                nib = digit_value(c);
                if (hex_cnt >= tep_pkg::HEX_MAX || nib < 0)
                begin
                    scan_mode = tep_pkg::MODE_IDLE;
                end
                else
                begin
                    // Digits fill from the red high nibble down; the seventh is dropped.
                    if (hex_cnt < tep_pkg::HEX_KEEP)
                    begin
                        bits = 24'(nib) << (4 * (int'(tep_pkg::HEX_TOP) - int'(hex_cnt)));
                        if (colour_sel)
                        begin
                            back_rgb[23:0] = back_rgb[23:0] | bits;
                        end
                        else
                        begin
                            text_rgb = text_rgb | bits;
                        end
                    end
                    hex_cnt = hex_cnt + 3'd1;
                end
            end
            default:
            begin
                scan_mode = tep_pkg::MODE_IDLE;
                if (c == tep_pkg::CH_BSLASH)
                begin
                    scan_mode = tep_pkg::MODE_ESC;
                end
                else
                begin
                    draws = 1'b1;
                end
            end
        endcase
        if (draws)
        begin
            g.glyph_code   = c;
            g.is_bold      = style_bits[tep_pkg::FLAG_BOLD];
            g.is_italic    = style_bits[tep_pkg::FLAG_ITALIC];
            g.is_underline = style_bits[tep_pkg::FLAG_UNDERLINE];
            g.is_strike    = style_bits[tep_pkg::FLAG_STRIKE];
            g.text_red     = text_rgb[23:16];
            g.text_green   = text_rgb[15:8];
            g.text_blue    = text_rgb[7:0];
            g.back_red     = back_rgb[23:16];
            g.back_green   = back_rgb[15:8];
            g.back_blue    = back_rgb[7:0];
            g.back_clear   = back_rgb[24];
            expected_glyphs.push_back(g);
        end
    endtask

    task automatic check_field(input string name, input logic [7:0] want,
                               input logic [7:0] got);
        if (want != got)
        begin
            error_count++;
            $display("%0t: %s mismatch, expected 0x%0h, actual 0x%0h",
                     $time, name, want, got);
        end
    endtask

    // Input side: a taken word goes through the predictor.
    always @(posedge clk)
    begin
        if (rst_n && char_valid && !char_stall)
        begin
            parse_char(char_word);
            char_taken = 1'b1;
        end
    end

    // Byte driver: holds a word until taken, idles at random.
    always @(negedge clk)
    begin
        if (!rst_n)
        begin
            char_valid <= 1'b0;
        end
        else if (!char_valid || char_taken)
        begin
            char_taken = 1'b0;
            if (pending_chars.size() != 0 && $urandom_range(99) >= sender_idle_pct)
            begin
                char_word  <= pending_chars.pop_front();
                char_valid <= 1'b1;
            end
            else
            begin
                char_valid <= 1'b0;
            end
        end
    end

    // Receiver stall.
    always @(negedge clk)
    begin
        glyph_stall <= rst_n && ($urandom_range(99) < receiver_stall_pct);
    end

    // Glyph monitor: compares each taken word with the oldest prediction.
    always @(posedge clk)
    begin
        tep_pkg::glyph_word_t want;
        if (rst_n && glyph_valid && !glyph_stall)
        begin
            if (expected_glyphs.size() == 0)
            begin
                error_count++;
                $display("%0t: unexpected glyph word, expected none, actual 0x%0h",
                         $time, glyph_word);
            end
            else
            begin
                want = expected_glyphs.pop_front();
                check_field("glyph_code", want.glyph_code, glyph_word.glyph_code);
                check_field("is_bold", 8'(want.is_bold), 8'(glyph_word.is_bold));
                check_field("is_italic", 8'(want.is_italic), 8'(glyph_word.is_italic));
                check_field("is_underline", 8'(want.is_underline),
                            8'(glyph_word.is_underline));
                check_field("is_strike", 8'(want.is_strike), 8'(glyph_word.is_strike));
                check_field("text_red", want.text_red, glyph_word.text_red);
                check_field("text_green", want.text_green, glyph_word.text_green);
                check_field("text_blue", want.text_blue, glyph_word.text_blue);
                check_field("back_red", want.back_red, glyph_word.back_red);
                check_field("back_green", want.back_green, glyph_word.back_green);
                check_field("back_blue", want.back_blue, glyph_word.back_blue);
                check_field("back_clear", 8'(want.back_clear), 8'(glyph_word.back_clear));
            end
        end
    end

    task automatic send_char(input logic [7:0] c, input logic som);
        tep_pkg::char_word_t w;
        w.char_in = c;
        w.start_of_message = som;
        pending_chars.push_back(w);
        chars_queued++;
    endtask

    // Random byte that now and then opens a new message, even mid-escape.
    task automatic send_random_mark(input logic [7:0] c);
        send_char(c, $urandom_range(99) < 3);
    endtask

    function automatic logic [7:0] any_hex_char(input int n);
        if (n < 10)
        begin
            return tep_pkg::CH_ZERO + 8'(n);
        end
        if ($urandom_range(1) == 1)
        begin
            return CH_LOWER_A + 8'(n - 10);
        end
        return CH_UPPER_A + 8'(n - 10);
    endfunction

    // One random run: mostly well-formed escapes and plain text, some noise.
    task automatic send_random_run();
        int          pick;
        int          digits;
        logic [7:0]  c;
        pick = $urandom_range(99);
        if (pick < 35)
        begin
            repeat ($urandom_range(4, 1))
            begin
                do c = 8'($urandom_range(255)); while (c == tep_pkg::CH_BSLASH);
                send_random_mark(c);
            end
        end
        else if (pick < 55)
        begin
            send_random_mark(tep_pkg::CH_BSLASH);
            case ($urandom_range(3))
                0: send_random_mark(tep_pkg::CH_B);
                1: send_random_mark(tep_pkg::CH_I);
                2: send_random_mark(tep_pkg::CH_U);
                default: send_random_mark(tep_pkg::CH_S);
            endcase
            if ($urandom_range(99) < 80)
            begin
                send_random_mark($urandom_range(1) == 1 ? tep_pkg::CH_ONE : tep_pkg::CH_ZERO);
            end
            else
            begin
                send_random_mark(8'($urandom_range(255)));
            end
        end
        else if (pick < 80)
        begin
            send_random_mark(tep_pkg::CH_BSLASH);
            send_random_mark($urandom_range(1) == 1 ? tep_pkg::CH_H : tep_pkg::CH_C);
            pick = $urandom_range(99);
            if (pick < 15)
            begin
                send_random_mark(tep_pkg::CH_ZERO);
                send_random_mark(8'($urandom_range(255)));
            end
            else if (pick < 90)
            begin
                send_random_mark(tep_pkg::CH_HASH);
                digits = $urandom_range(7);
                repeat (digits) send_random_mark(any_hex_char($urandom_range(15)));
                if (digits == 7)
                begin
                    send_random_mark(8'($urandom_range(255)));
                end
                else if ($urandom_range(1) == 1)
                begin
                    send_random_mark(CH_SEMI);
                end
                else
                begin
                    do c = 8'($urandom_range(255)); while (digit_value(c) >= 0);
                    send_random_mark(c);
                end
            end
            else
            begin
                send_random_mark(8'($urandom_range(255)));
            end
        end
        else if (pick < 88)
        begin
            send_random_mark(tep_pkg::CH_BSLASH);
            send_random_mark(tep_pkg::CH_BSLASH);
        end
        else if (pick < 95)
        begin
            send_random_mark(tep_pkg::CH_BSLASH);
            send_random_mark(8'($urandom_range(255)));
        end
        else
        begin
            send_random_mark(8'($urandom_range(255)));
        end
    endtask

    task automatic wait_for_drain();
        while (pending_chars.size() != 0 || char_valid || expected_glyphs.size() != 0)
        begin
            @(posedge clk);
        end
    endtask

    // Stimulus: directed escapes, then random runs across idling phases.
    initial
    begin
        int unsigned phase_end;
        clear_attributes();
        wait (rst_n);

        // Plain bytes at the extremes, from a fresh message.
        send_char(CH_LETTER_M, 1'b1);
        send_char(8'h00, 1'b0);
        send_char(8'hFF, 1'b0);
        // Every style flag set, then bold cleared.
        send_char(tep_pkg::CH_BSLASH, 1'b0);
        send_char(tep_pkg::CH_B, 1'b0);
        send_char(tep_pkg::CH_ZERO, 1'b0);
        send_char(tep_pkg::CH_BSLASH, 1'b0);
        send_char(tep_pkg::CH_I, 1'b0);
        send_char(tep_pkg::CH_ZERO, 1'b0);
        send_char(tep_pkg::CH_BSLASH, 1'b0);
        send_char(tep_pkg::CH_U, 1'b0);
        send_char(tep_pkg::CH_ZERO, 1'b0);
        send_char(tep_pkg::CH_BSLASH, 1'b0);
        send_char(tep_pkg::CH_S, 1'b0);
        send_char(tep_pkg::CH_ZERO, 1'b0);
        send_char(CH_LETTER_X, 1'b0);
        send_char(tep_pkg::CH_BSLASH, 1'b0);
        send_char(tep_pkg::CH_B, 1'b0);
        send_char(tep_pkg::CH_ONE, 1'b0);
        // Unknown letter, and a flag value that is neither zero nor one.
        send_char(tep_pkg::CH_BSLASH, 1'b0);
        send_char(CH_LOWER_Q, 1'b0);
        send_char(tep_pkg::CH_BSLASH, 1'b0);
        send_char(tep_pkg::CH_S, 1'b0);
        send_char(CH_SEVEN, 1'b0);
        send_char(CH_LETTER_Y, 1'b0);
        // Highlight with seven digits: the last is dropped, the next byte eaten.
        send_char(tep_pkg::CH_BSLASH, 1'b0);
        send_char(tep_pkg::CH_H, 1'b0);
        send_char(tep_pkg::CH_HASH, 1'b0);
        send_char(any_hex_char(15), 1'b0);
        send_char(CH_UPPER_A, 1'b0);
        send_char(tep_pkg::CH_ZERO, 1'b0);
        send_char(CH_LOWER_A + 8'd5, 1'b0);
        send_char(tep_pkg::CH_ZERO + 8'd9, 1'b0);
        send_char(CH_UPPER_A + 8'd1, 1'b0);
        send_char(CH_SEVEN, 1'b0);
        send_char(CH_LETTER_Z, 1'b0);
        send_char(CH_LETTER_Z, 1'b0);
        // Text colour ended by a semicolon, then a bad selector.
        send_char(tep_pkg::CH_BSLASH, 1'b0);
        send_char(tep_pkg::CH_C, 1'b0);
        send_char(tep_pkg::CH_HASH, 1'b0);
        send_char(tep_pkg::CH_ZERO + 8'd1, 1'b0);
        send_char(CH_SEMI, 1'b0);
        send_char(tep_pkg::CH_BSLASH, 1'b0);
        send_char(tep_pkg::CH_C, 1'b0);
        send_char(CH_LOWER_X, 1'b0);
        send_char(CH_LETTER_X, 1'b0);
        // Default colour eats a backslash; a doubled backslash draws nothing.
        send_char(tep_pkg::CH_BSLASH, 1'b0);
        send_char(tep_pkg::CH_C, 1'b0);
        send_char(tep_pkg::CH_ZERO, 1'b0);
        send_char(tep_pkg::CH_BSLASH, 1'b0);
        send_char(tep_pkg::CH_BSLASH, 1'b0);
        send_char(tep_pkg::CH_BSLASH, 1'b0);
        send_char(CH_LETTER_Y, 1'b0);
        // A message cut off inside an escape.
        send_char(tep_pkg::CH_BSLASH, 1'b0);
        send_char(tep_pkg::CH_H, 1'b0);
        send_char(CH_LETTER_M, 1'b1);

        // Idling phases: none, sender, receiver, then both.
        for (int phase = 0; phase < 4; phase++)
        begin
            case (phase)
                0:
                begin
                    sender_idle_pct    = 0;
                    receiver_stall_pct = 0;
                end
                1:
                begin
                    sender_idle_pct    = 64;
                    receiver_stall_pct = 0;
                end
                2:
                begin
                    sender_idle_pct    = 0;
                    receiver_stall_pct = 64;
                end
                default:
                begin
                    sender_idle_pct    = 16;
                    receiver_stall_pct = 16;
                end
            endcase
            phase_end = chars_queued + RANDOM_PER_PHASE;
            while (chars_queued < phase_end)
            begin
                send_random_run();
            end
            while (pending_chars.size() != 0)
            begin
                @(posedge clk);
            end
        end

        wait_for_drain();
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (error_count == 0 && expected_glyphs.size() == 0)
        begin
            $display("Simulation PASSED");
        end
        else
        begin
            $display("Simulation FAILED");
        end
        $finish;
    end

    // Run limit, far above the slowest correct run.
    initial
    begin
        #2ms;
        $display("Simulation FAILED");
        $finish;
    end

endmodule

### sim.f
src/tep_pkg.sv
src/tep_parse.sv
src/text_escape_attribute_parser_core.sv
bench/testbench.sv
